// ----- sv/mer_pkg.sv -----
// mer_pkg: shared constants, codes and control types for the ellipse rasterizer
// no dependencies; imported by the channel interfaces, the controller, the datapath
// and the checker
package mer_pkg;

	localparam int AXIS_BITS_DEF  = 10;
	localparam int COORD_BITS_DEF = 12;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		MUL_AA,
		MUL_BB,
		MUL_A2B,
		MUL_A2A2
	} mul_sel_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_A2,
		CAP_B2,
		CAP_A2B,
		CAP_A4
	} cap_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		cap_sel_t cap_sel;
		logic     init;
		logic     step;
		logic     adj;
	} dp_cmd_t;

	typedef struct packed {
		logic fail;
		logic to_region_two;
	} dp_stat_t;

endpackage

// ----- sv/mer_cmd_if.sv -----
// mer_cmd_if: input channel carrying one start or advance word
// depends on mer_pkg for default widths
interface mer_cmd_if #(
	parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] origin_x;
	logic signed [COORD_BITS-1:0] origin_y;
	logic        [AXIS_BITS-1:0]  semi_axis_a;
	logic        [AXIS_BITS-1:0]  semi_axis_b;

	modport source (output valid, action, origin_x, origin_y, semi_axis_a, semi_axis_b,
		input ready);
	modport sink (input valid, action, origin_x, origin_y, semi_axis_a, semi_axis_b,
		output ready);
endinterface

// ----- sv/mer_pix_if.sv -----
// mer_pix_if: output channel carrying one group of four mirrored points
// depends on mer_pkg for default widths
interface mer_pix_if #(
	parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] px_pos_x;
	logic signed [COORD_BITS:0] px_neg_x;
	logic signed [COORD_BITS:0] py_pos_y;
	logic signed [COORD_BITS:0] py_neg_y;
	logic [AXIS_BITS-1:0]       offset_x;
	logic [AXIS_BITS-1:0]       offset_y;
	logic                       in_second_region;
	logic                       last_group;

	modport source (output valid, px_pos_x, px_neg_x, py_pos_y, py_neg_y, offset_x, offset_y,
		in_second_region, last_group, input ready);
	modport sink (input valid, px_pos_x, px_neg_x, py_pos_y, py_neg_y, offset_x, offset_y,
		in_second_region, last_group, output ready);
endinterface

// ----- sv/mer_ctrl.sv -----
// mer_ctrl: sequencer for setup multiplies, point steps and region switch
// depends on mer_pkg; drives mer_dp through dp_cmd_t, reads dp_stat_t
module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	input  mer_pkg::dp_stat_t stat,
	output mer_pkg::dp_cmd_t  cmd
);
	import mer_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MA   = 8'b0000_0010,
		S_MB   = 8'b0000_0100,
		S_MAB  = 8'b0000_1000,
		S_MAA  = 8'b0001_0000,
		S_INIT = 8'b0010_0000,
		S_STEP = 8'b0100_0000,
		S_ADJ  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   active_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == ACT_START) begin
						cmd.load = 1'b1;
						state_d  = S_MA;
					end else if (active_q) begin
						state_d = S_STEP;
					end
				end
			end
			S_MA: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AA;
				state_d     = S_MB;
			end
			S_MB: begin
				cmd.cap_sel = CAP_A2;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BB;
				state_d     = S_MAB;
			end
			S_MAB: begin
				cmd.cap_sel = CAP_B2;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_A2B;
				state_d     = S_MAA;
			end
			S_MAA: begin
				cmd.cap_sel = CAP_A2B;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_A2A2;
				state_d     = S_INIT;
			end
			S_INIT: begin
				cmd.cap_sel = CAP_A4;
				cmd.init    = 1'b1;
				state_d     = S_STEP;
			end
			S_STEP: begin
				if (out_free) begin
					cmd.step = 1'b1;
					if (stat.fail) begin
						state_d = S_IDLE;
					end else if (stat.to_region_two) begin
						state_d = S_ADJ;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ADJ: begin
				cmd.adj = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.init) begin
				active_q <= 1'b1;
			end else if (cmd.step && stat.fail) begin
				active_q <= 1'b0;
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/mer_dp.sv -----
// mer_dp: ellipse datapath with shared setup multiplier, incremental step terms
// and output word register; depends on mer_pkg, controlled by mer_ctrl
module mer_dp #(
	parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  mer_pkg::dp_cmd_t             cmd,
	output mer_pkg::dp_stat_t            stat,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	input  logic        [AXIS_BITS-1:0]  semi_axis_a,
	input  logic        [AXIS_BITS-1:0]  semi_axis_b,
	output logic signed [COORD_BITS:0]   px_pos_x,
	output logic signed [COORD_BITS:0]   px_neg_x,
	output logic signed [COORD_BITS:0]   py_pos_y,
	output logic signed [COORD_BITS:0]   py_neg_y,
	output logic        [AXIS_BITS-1:0]  offset_x,
	output logic        [AXIS_BITS-1:0]  offset_y,
	output logic                         in_second_region,
	output logic                         last_group
);
	import mer_pkg::*;

	localparam int SQ_W = 2 * AXIS_BITS;
	localparam int AB_W = 3 * AXIS_BITS;
	localparam int P_W  = 4 * AXIS_BITS;
	localparam int D_W  = 4 * AXIS_BITS + 4;
	localparam int S_W  = 4 * AXIS_BITS + 4;
	localparam int Q_W  = D_W + 3;
	localparam int XW   = AXIS_BITS + 2;
	localparam int E_W  = COORD_BITS + AXIS_BITS + 3;
	localparam int O_W  = COORD_BITS + 1;

	// quarter units back to integer, rounding toward zero
	function automatic logic signed [Q_W-1:0] trunc4(input logic signed [Q_W-1:0] q);
		logic signed [Q_W-1:0] r;
		r = q >>> 2;
		if (q[Q_W-1] && (q[1:0] != 2'b00)) begin
			r = r + Q_W'(1);
		end
		return r;
	endfunction

	logic        [AXIS_BITS-1:0]  a_q, b_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic                         zero_q;
	logic        [P_W-1:0]        p_q;
	logic        [SQ_W-1:0]       a2_q, b2_q;
	logic        [AB_W-1:0]       a2b_q;
	logic        [P_W-1:0]        a4_q;
	logic        [XW-1:0]         x_q;
	logic        [AXIS_BITS-1:0]  y_q;
	logic                         reg2_q;
	logic signed [D_W-1:0]        d_q, dx_q, dy_q;
	logic        [S_W-1:0]        s_q, t_q;

	logic        [SQ_W-1:0]       mul_a, mul_b;
	logic signed [D_W-1:0]        a2_d, b2_d, two_a2, two_b2;
	logic        [S_W-1:0]        ab_s, s1, t1;
	logic                         dpos, dneg, y_zero, fail1;
	logic signed [D_W-1:0]        dy1, dx_inc, d1, dy2, dx2, d2;
	logic        [XW-1:0]         x_inc;
	logic        [AXIS_BITS-1:0]  y_dec;
	logic signed [Q_W-1:0]        a2_q4, b2_q4, a2b_q4, q_init, q_adj, dsum;
	logic signed [Q_W-1:0]        r_init, r_adj;
	logic signed [E_W-1:0]        cx_e, cy_e, x_e, y_e;
	logic signed [E_W-1:0]        sum_px, sum_nx, sum_py, sum_ny;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_AA: begin
				mul_a = SQ_W'(a_q);
				mul_b = SQ_W'(a_q);
			end
			MUL_BB: begin
				mul_a = SQ_W'(b_q);
				mul_b = SQ_W'(b_q);
			end
			MUL_A2B: begin
				mul_a = a2_q;
				mul_b = SQ_W'(b_q);
			end
			MUL_A2A2: begin
				mul_a = a2_q;
				mul_b = a2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign a2_d   = $signed(D_W'(a2_q));
	assign b2_d   = $signed(D_W'(b2_q));
	assign two_a2 = a2_d <<< 1;
	assign two_b2 = b2_d <<< 1;
	assign ab_s   = S_W'(a2_q) + S_W'(b2_q);

	// region one step
	assign dpos   = d_q > 0;
	assign dneg   = d_q < 0;
	assign y_zero = (y_q == '0);
	assign fail1  = dpos && y_zero;
	assign x_inc  = x_q + XW'(1);
	assign y_dec  = y_q - AXIS_BITS'(1);
	assign dx_inc = dx_q + two_b2;
	assign dy1    = dpos ? (dy_q - two_a2) : dy_q;
	assign d1     = d_q - (dpos ? dy1 : D_W'(0)) + dx_inc + b2_d;
	assign s1     = s_q + t_q;
	assign t1     = t_q + (ab_s << 1);

	// region two step
	assign dy2 = dy_q - two_a2;
	assign dx2 = dneg ? dx_inc : dx_q;
	assign d2  = d_q + (dneg ? dx_inc : D_W'(0)) + a2_d - dy2;

	assign stat.fail          = zero_q || (reg2_q ? y_zero : fail1);
	assign stat.to_region_two = !reg2_q && !fail1 && (s1 > S_W'(a4_q));

	// start value and region switch in quarter units
	assign a2_q4  = $signed(Q_W'(a2_q));
	assign b2_q4  = $signed(Q_W'(b2_q));
	assign a2b_q4 = $signed(Q_W'(a2b_q));
	assign q_init = (b2_q4 <<< 2) - (a2b_q4 <<< 2) + a2_q4;
	assign dsum   = $signed({{3{dx_q[D_W-1]}}, dx_q}) + $signed({{3{dy_q[D_W-1]}}, dy_q});
	assign q_adj  = ($signed({{3{d_q[D_W-1]}}, d_q}) <<< 2)
		+ ((a2_q4 - b2_q4) <<< 1) + (a2_q4 - b2_q4) - (dsum <<< 1);
	assign r_init = trunc4(q_init);
	assign r_adj  = trunc4(q_adj);

	// mirrored coordinates of the current group
	assign cx_e   = $signed({{(E_W-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q});
	assign cy_e   = $signed({{(E_W-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q});
	assign x_e    = $signed(E_W'(x_q));
	assign y_e    = $signed(E_W'(y_q));
	assign sum_px = cx_e + x_e;
	assign sum_nx = cx_e - x_e;
	assign sum_py = cy_e + y_e;
	assign sum_ny = cy_e - y_e;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= semi_axis_a;
			b_q    <= semi_axis_b;
			cx_q   <= origin_x;
			cy_q   <= origin_y;
			zero_q <= (semi_axis_a == '0) || (semi_axis_b == '0);
		end
		if (cmd.mul_en) begin
			p_q <= P_W'(mul_a * mul_b);
		end
		unique case (cmd.cap_sel)
			CAP_NONE: begin
			end
			CAP_A2:  a2_q  <= p_q[SQ_W-1:0];
			CAP_B2:  b2_q  <= p_q[SQ_W-1:0];
			CAP_A2B: a2b_q <= p_q[AB_W-1:0];
			CAP_A4:  a4_q  <= p_q;
			default: begin
			end
		endcase
		if (cmd.init) begin
			x_q    <= '0;
			y_q    <= b_q;
			reg2_q <= 1'b0;
			d_q    <= r_init[D_W-1:0];
			dx_q   <= '0;
			dy_q   <= $signed(D_W'(a2b_q)) <<< 1;
			s_q    <= '0;
			t_q    <= ab_s;
		end else if (cmd.step) begin
			if (!reg2_q) begin
				x_q  <= x_inc;
				y_q  <= dpos ? y_dec : y_q;
				d_q  <= d1;
				dx_q <= dx_inc;
				dy_q <= dy1;
				s_q  <= s1;
				t_q  <= t1;
			end else begin
				x_q  <= dneg ? x_inc : x_q;
				y_q  <= y_dec;
				d_q  <= d2;
				dx_q <= dx2;
				dy_q <= dy2;
			end
		end else if (cmd.adj) begin
			reg2_q <= 1'b1;
			d_q    <= r_adj[D_W-1:0];
		end
		if (cmd.step) begin
			px_pos_x         <= sum_px[O_W-1:0];
			px_neg_x         <= sum_nx[O_W-1:0];
			py_pos_y         <= sum_py[O_W-1:0];
			py_neg_y         <= sum_ny[O_W-1:0];
			offset_x         <= x_q[AXIS_BITS-1:0];
			offset_y         <= y_q;
			in_second_region <= reg2_q;
			last_group       <= stat.fail;
		end
	end

endmodule

// ----- sv/midpoint_ellipse_rasterizer.sv -----
// midpoint_ellipse_rasterizer: top level joining controller and datapath
// depends on mer_pkg, mer_cmd_if, mer_pix_if, mer_ctrl, mer_dp
//
// usage
//   cmd channel: action 0 starts an ellipse from origin_x/origin_y and the
//   semi-axes, action 1 asks for the next group of four mirrored points
//   pix channel: one word per group, last_group marks the end of the ellipse
//   an advance with no ellipse running is taken and gives no word
// sequencing
//   start: the word is loaded; the setup runs four products through the single
//   shared multiplier, then an init step and the first point step
//   advance: one point step, held while the output word waits; a decision adjust
//   step follows when the walk crosses from the flat to the steep region
//   one cmd word in flight at a time: the input is open only in idle
// reset and stalls
//   reset clears the sequencer, the running flag and the output valid
//   the output word is held in a register; a new cmd word is taken while it
//   waits, and the step stalls until the receiver takes the previous word
module midpoint_ellipse_rasterizer #(
	parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mer_cmd_if.sink   cmd,
	mer_pix_if.source pix
);
	import mer_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_action (cmd.action),
		.in_ready  (cmd.ready),
		.out_ready (pix.ready),
		.out_valid (pix.valid),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	mer_dp #(
		.AXIS_BITS  (AXIS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk              (clk),
		.cmd              (dp_cmd),
		.stat             (dp_stat),
		.origin_x         (cmd.origin_x),
		.origin_y         (cmd.origin_y),
		.semi_axis_a      (cmd.semi_axis_a),
		.semi_axis_b      (cmd.semi_axis_b),
		.px_pos_x         (pix.px_pos_x),
		.px_neg_x         (pix.px_neg_x),
		.py_pos_y         (pix.py_pos_y),
		.py_neg_y         (pix.py_neg_y),
		.offset_x         (pix.offset_x),
		.offset_y         (pix.offset_y),
		.in_second_region (pix.in_second_region),
		.last_group       (pix.last_group)
	);

endmodule

// ----- sv/mer_checker.sv -----
// mer_checker: port-level checks of the ellipse rasterizer, bound to the top level
// depends on mer_pkg and midpoint_ellipse_rasterizer
module mer_checker #(
	parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       cmd_action,
	input logic                       pix_valid,
	input logic                       pix_ready,
	input logic signed [COORD_BITS:0] px_pos_x,
	input logic signed [COORD_BITS:0] px_neg_x,
	input logic signed [COORD_BITS:0] py_pos_y,
	input logic signed [COORD_BITS:0] py_neg_y,
	input logic [AXIS_BITS-1:0]       offset_x,
	input logic [AXIS_BITS-1:0]       offset_y,
	input logic                       last_group
);
	import mer_pkg::*;

	localparam int K = (COORD_BITS + 1 < AXIS_BITS + 1) ? COORD_BITS + 1 : AXIS_BITS + 1;

	logic [COORD_BITS:0] diff_x, diff_y;

	assign diff_x = px_pos_x - px_neg_x;
	assign diff_y = py_pos_y - py_neg_y;

	// held word keeps its offsets and last flag under backpressure
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(offset_x) && $stable(offset_y)
			&& $stable(last_group))
		else $error("output word changed while stalled");

	// mirrored points sit symmetric about the center
	a_mirror_x: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> diff_x[K-1:0] == K'({offset_x, 1'b0}))
		else $error("x mirror points inconsistent with offset");

	a_mirror_y: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> diff_y[K-1:0] == K'({offset_y, 1'b0}))
		else $error("y mirror points inconsistent with offset");

	// setup multiplies keep the input closed right after a start
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_action == ACT_START) |=> !cmd_ready)
		else $error("input taken during setup");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
	.AXIS_BITS  (AXIS_BITS),
	.COORD_BITS (COORD_BITS)
) u_mer_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_action (cmd.action),
	.pix_valid  (pix.valid),
	.pix_ready  (pix.ready),
	.px_pos_x   (pix.px_pos_x),
	.px_neg_x   (pix.px_neg_x),
	.py_pos_y   (pix.py_pos_y),
	.py_neg_y   (pix.py_neg_y),
	.offset_x   (pix.offset_x),
	.offset_y   (pix.offset_y),
	.last_group (pix.last_group)
);

// ----- test/midpoint_ellipse_rasterizer_chk.sv -----
// midpoint_ellipse_rasterizer_chk: watches the cmd and pix channels, predicts each group
// from its own midpoint walk and compares it field by field
// depends on mer_pkg, mer_cmd_if and mer_pix_if
module midpoint_ellipse_rasterizer_chk (
	input  logic clk,
	input  logic arst_n,
	mer_cmd_if   cmd,
	mer_pix_if   pix,
	output int   fail_cnt,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mer_pkg::*;

	localparam int AB = AXIS_BITS_DEF;
	localparam int CB = COORD_BITS_DEF;

	typedef struct packed {
		logic signed [CB:0] pos_x;
		logic signed [CB:0] neg_x;
		logic signed [CB:0] pos_y;
		logic signed [CB:0] neg_y;
		logic [AB-1:0]      off_x;
		logic [AB-1:0]      off_y;
		logic               steep;
		logic               last;
	} point_group_t;

	point_group_t groups_due[$];
	point_group_t want;

	longint walk_x, walk_y, dec, a_sq, b_sq, ctr_x, ctr_y;
	bit     steep, running;

	function automatic point_group_t make_group(longint x, longint y, bit r, bit last);
		point_group_t g;
		g.pos_x = (CB+1)'(ctr_x + x);
		g.neg_x = (CB+1)'(ctr_x - x);
		g.pos_y = (CB+1)'(ctr_y + y);
		g.neg_y = (CB+1)'(ctr_y - y);
		g.off_x = x[AB-1:0];
		g.off_y = y[AB-1:0];
		g.steep = r;
		g.last  = last;
		return g;
	endfunction

	// one midpoint step; 0 when the ellipse has ended
	function automatic bit walk_on();
		if (!steep) begin
			walk_x += 1;
			if (dec > 0) begin
				if (walk_y == 0)
					return 1'b0;
				walk_y -= 1;
				dec -= 2 * a_sq * walk_y;
			end
			dec += b_sq * (2 * walk_x + 1);
			if (walk_x * walk_x * (a_sq + b_sq) > a_sq * a_sq) begin
				dec = (4 * dec + 3 * (a_sq - b_sq) - 4 * (b_sq * walk_x + a_sq * walk_y)) / 4;
				steep = 1'b1;
			end
			return 1'b1;
		end
		if (walk_y == 0)
			return 1'b0;
		walk_y -= 1;
		if (dec < 0) begin
			walk_x += 1;
			dec += 2 * b_sq * walk_x;
		end
		dec += a_sq * (1 - 2 * walk_y);
		return 1'b1;
	endfunction

	task automatic take_word(input logic act, input longint cx, input longint cy,
		input longint a, input longint b);
		longint sx, sy;
		bit     sr, done;
		if (act == ACT_START) begin
			ctr_x   = cx;
			ctr_y   = cy;
			a_sq    = a * a;
			b_sq    = b * b;
			walk_x  = 0;
			walk_y  = b;
			steep   = 1'b0;
			dec     = (4 * b_sq - 4 * a_sq * b + a_sq) / 4;
			running = 1'b1;
			if (a == 0 || b == 0) begin
				groups_due.push_back(make_group(walk_x, walk_y, steep, 1'b1));
				running = 1'b0;
				return;
			end
		end else if (!running) begin
			return;
		end
		sx = walk_x;
		sy = walk_y;
		sr = steep;
		done = !walk_on();
		groups_due.push_back(make_group(sx, sy, sr, done));
		if (done)
			running = 1'b0;
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_due.delete();
			walk_x   = 0;
			walk_y   = 0;
			dec      = 0;
			a_sq     = 0;
			b_sq     = 0;
			ctr_x    = 0;
			ctr_y    = 0;
			steep    = 1'b0;
			running  = 1'b0;
			fail_cnt = 0;
			pending  <= 0;
		end else begin
			if (pix.valid && pix.ready) begin
				if (groups_due.size() == 0) begin
					$display("%0t: unexpected word, expected none actual offset (%0d,%0d)",
						$time, pix.offset_x, pix.offset_y);
					fail_cnt++;
				end else begin
					want = groups_due.pop_front();
					check_field("px_pos_x", want.pos_x, pix.px_pos_x);
					check_field("px_neg_x", want.neg_x, pix.px_neg_x);
					check_field("py_pos_y", want.pos_y, pix.py_pos_y);
					check_field("py_neg_y", want.neg_y, pix.py_neg_y);
					check_field("offset_x", want.off_x, pix.offset_x);
					check_field("offset_y", want.off_y, pix.offset_y);
					check_field("in_second_region", want.steep, pix.in_second_region);
					check_field("last_group", want.last, pix.last_group);
				end
			end
			if (cmd.valid && cmd.ready)
				take_word(cmd.action, longint'(cmd.origin_x), longint'(cmd.origin_y),
					longint'(cmd.semi_axis_a), longint'(cmd.semi_axis_b));
			pending <= groups_due.size();
		end
	end

endmodule

// ----- test/midpoint_ellipse_rasterizer_tb.sv -----
// midpoint_ellipse_rasterizer_tb: drives start and advance words with random gaps and stalls
// depends on mer_pkg, mer_cmd_if, mer_pix_if, midpoint_ellipse_rasterizer and
// midpoint_ellipse_rasterizer_chk
module midpoint_ellipse_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mer_pkg::*;

	localparam int CB         = COORD_BITS_DEF;
	localparam int AB         = AXIS_BITS_DEF;
	localparam int WORDS      = 700;
	localparam int CYCLE_CAP  = 300000;

	logic clk;
	logic arst_n;
	int   fail_cnt;
	int   pending;
	int   cycles;
	int   n_words;
	bit   calm;

	mer_cmd_if cmd_ch();
	mer_pix_if pix_ch();

	midpoint_ellipse_rasterizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pix    (pix_ch)
	);

	midpoint_ellipse_rasterizer_chk chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.pix      (pix_ch),
		.fail_cnt (fail_cnt),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("midpoint_ellipse_rasterizer_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		pix_ch.ready <= calm || ($urandom_range(99) >= 35);
	end

	task automatic put_word(input logic act, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
		input logic [AB-1:0] a, input logic [AB-1:0] b);
		while (!calm && $urandom_range(99) < 35) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.action      <= act;
		cmd_ch.origin_x    <= cx;
		cmd_ch.origin_y    <= cy;
		cmd_ch.semi_axis_a <= a;
		cmd_ch.semi_axis_b <= b;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		n_words++;
	endtask

	task automatic put_advance();
		put_word(ACT_ADVANCE, CB'($urandom()), CB'($urandom()), AB'($urandom()),
			AB'($urandom()));
	endtask

	task automatic run_ellipse(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
		input logic [AB-1:0] a, input logic [AB-1:0] b, input int steps);
		put_word(ACT_START, cx, cy, a, b);
		repeat (steps)
			put_advance();
	endtask

	initial begin
		int a, b, steps, pick;
		cycles   = 0;
		n_words  = 0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.action      <= ACT_START;
		cmd_ch.origin_x    <= '0;
		cmd_ch.origin_y    <= '0;
		cmd_ch.semi_axis_a <= '0;
		cmd_ch.semi_axis_b <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle advance, tiny circle, zero axes, extremes, restart, flat
		put_advance();
		run_ellipse(12'sd0, 12'sd0, 10'd1, 10'd1, 3);
		run_ellipse(12'sd2047, 12'sh800, 10'd0, 10'd5, 1);
		run_ellipse(12'sh800, 12'sd2047, 10'd7, 10'd0, 0);
		run_ellipse(12'sd2047, 12'sd2047, 10'd1023, 10'd1023, 2);
		run_ellipse(12'sh800, 12'sh800, 10'd1023, 10'd1, 2);
		run_ellipse(-12'sd1, 12'sd1, 10'd12, 10'd1, 12);

		while (n_words < WORDS + 27) begin
			calm = (n_words >= 300 && n_words < 420);
			pick = $urandom_range(99);
			if (pick < 3) begin
				a = $urandom_range(25, 250);
				b = $urandom_range(25, 250);
				steps = a + b + 4;
			end else if (pick < 10) begin
				a = $urandom_range(0, 1023);
				b = $urandom_range(0, 1023);
				steps = $urandom_range(0, 30);
			end else if (pick < 16) begin
				a = $urandom_range(8, 60);
				b = $urandom_range(1, 3);
				if ($urandom_range(1)) begin
					int t;
					t = a;
					a = b;
					b = t;
				end
				steps = a + b + 4;
			end else begin
				a = $urandom_range(1, 24);
				b = $urandom_range(1, 24);
				steps = $urandom_range(0, a + b + 4);
			end
			if ($urandom_range(99) < 5)
				put_advance();
			run_ellipse(CB'($urandom()), CB'($urandom()), AB'(a), AB'(b), steps);
		end
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (fail_cnt == 0)
			$display("midpoint_ellipse_rasterizer_tb OK");
		else
			$display("midpoint_ellipse_rasterizer_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/mer_pkg.sv
sv/mer_cmd_if.sv
sv/mer_pix_if.sv
sv/mer_ctrl.sv
sv/mer_dp.sv
sv/midpoint_ellipse_rasterizer.sv
sv/mer_checker.sv
test/midpoint_ellipse_rasterizer_chk.sv
test/midpoint_ellipse_rasterizer_tb.sv
